// ===== hw/rtl/sorted_table_range_search_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted table range search unit
// Concurrent checks on a clock with a synchronous active-high reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_RANGE_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_RANGE_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define SRS_ASSERT_HOLDS(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("srs check failed");

// next-cycle implication
`define SRS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("srs check failed");

`endif

// ===== hw/rtl/srs_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted table range search package
// Shared types, codes and defaults of the range search unit.
// ---------------------------------------------------------------------------
package srs_pkg;

   localparam int SRS_DEPTH_DEFAULT = 1024;
   localparam int VALUE_W           = 32;
   localparam int INDEX_W           = 11;
   localparam int MODE_W            = 2;
   localparam int STATUS_W          = 2;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_QUERY_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_APPENDED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd3;

   localparam logic signed [INDEX_W-1:0] NONE_INDEX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } srs_state_type;

endpackage

// ===== hw/rtl/srs_step.sv =====
// ---------------------------------------------------------------------------
// Range search probe step
// Compares one fetched element with the target and narrows the search window.
// ---------------------------------------------------------------------------
module srs_step
   import srs_pkg::*;
#(
   parameter int AddrWidth  = $clog2(SRS_DEPTH_DEFAULT),
   parameter int CountWidth = $clog2(SRS_DEPTH_DEFAULT + 1)
) (
   input  logic                      toward_right,
   input  logic [CountWidth-1:0]     lo,
   input  logic [CountWidth-1:0]     hi,
   input  logic [AddrWidth-1:0]      mid,
   input  logic signed [VALUE_W-1:0] data,
   input  logic signed [VALUE_W-1:0] target,
   output logic [CountWidth-1:0]     lo_next,
   output logic [CountWidth-1:0]     hi_next,
   output logic                      hit
);

   logic [CountWidth-1:0] mid_ext;
   logic                  equal;
   logic                  less;

   assign mid_ext = CountWidth'(mid);
   assign equal   = (data == target);
   assign less    = (data < target);

   // window is [lo, hi), hi exclusive
   always_comb begin
      lo_next = lo;
      hi_next = hi;
      hit     = 1'b0;
      if (equal) begin
         hit = 1'b1;
         if (toward_right) begin
            lo_next = mid_ext + CountWidth'(1);
         end else begin
            hi_next = mid_ext;
         end
      end else if (less) begin
         lo_next = mid_ext + CountWidth'(1);
      end else begin
         hi_next = mid_ext;
      end
   end

endmodule

// ===== hw/rtl/sorted_table_range_search_unit.sv =====
// ---------------------------------------------------------------------------
// Sorted table range search unit
// Table of signed values with append, clear and equal-range query.
// ---------------------------------------------------------------------------
// Holds up to DEPTH signed 32-bit values, appended in order and taken to be
// sorted nondecreasing (never checked). Clear and append go from idle straight
// to the finish state, which registers the result. A query runs a leftmost
// binary search over the filled entries and, only after a hit, a rightmost one;
// each probe is a memory read in the probe state, then a compare and window
// update in the compare state through one shared step unit. The input is
// stalled while an item is in work; the result register frees the input side
// while a result waits. Indices are reported in 11 bits, -1 meaning none.
`include "sorted_table_range_search_unit_macros.svh"

module sorted_table_range_search_unit
   import srs_pkg::*;
#(
   parameter int DEPTH = SRS_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic signed [INDEX_W-1:0]  rsp_first_index,
   output logic signed [INDEX_W-1:0]  rsp_last_index
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   srs_state_type state_ff, state_in;

   logic [CW-1:0]              count_ff, count_in;
   logic signed [VALUE_W-1:0]  target_ff, target_in;
   logic                       dir_ff, dir_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic [AW-1:0]              mid_ff, mid_in;
   logic                       hit_vld_ff, hit_vld_in;
   logic [AW-1:0]              hit_idx_ff, hit_idx_in;
   logic [STATUS_W-1:0]        res_status_ff, res_status_in;
   logic                       res_found_ff, res_found_in;
   logic signed [INDEX_W-1:0]  res_first_ff, res_first_in;
   logic signed [INDEX_W-1:0]  res_last_ff, res_last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic signed [INDEX_W-1:0]  rsp_first_ff, rsp_first_in;
   logic signed [INDEX_W-1:0]  rsp_last_ff, rsp_last_in;
   logic signed [VALUE_W-1:0]  rd_data_ff;

   logic signed [VALUE_W-1:0]  mem [DEPTH];

   logic          req_accept;
   logic          rsp_free;
   logic          probe_live;
   logic [CW-1:0] span;
   logic [CW-1:0] mid_calc;
   logic          wr_en;
   logic          rd_en;
   logic [CW-1:0] step_lo;
   logic [CW-1:0] step_hi;
   logic          step_hit;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign probe_live = (lo_ff < hi_ff);
   assign span       = hi_ff - lo_ff - CW'(1);
   assign mid_calc   = lo_ff + (span >> 1);

   srs_step #(
      .AddrWidth  (AW),
      .CountWidth (CW)
   ) u_step (
      .toward_right (dir_ff),
      .lo           (lo_ff),
      .hi           (hi_ff),
      .mid          (mid_ff),
      .data         (rd_data_ff),
      .target       (target_ff),
      .lo_next      (step_lo),
      .hi_next      (step_hi),
      .hit          (step_hit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_mode[1] ? ST_PROBE : ST_FINISH;
            end
         end
         ST_PROBE: begin
            if (probe_live) begin
               state_in = ST_COMPARE;
            end else if (!dir_ff && hit_vld_ff) begin
               state_in = ST_PROBE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_COMPARE: begin
            state_in = ST_PROBE;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      count_in      = count_ff;
      target_in     = target_ff;
      dir_in        = dir_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      hit_vld_in    = hit_vld_ff;
      hit_idx_in    = hit_idx_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_first_in  = res_first_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               target_in    = req_value;
               dir_in       = 1'b0;
               lo_in        = '0;
               hi_in        = count_ff;
               hit_vld_in   = 1'b0;
               res_found_in = 1'b0;
               res_first_in = NONE_INDEX;
               res_last_in  = NONE_INDEX;
               unique case (req_mode)
                  MODE_CLEAR: begin
                     count_in      = '0;
                     res_status_in = STATUS_CLEARED;
                  end
                  MODE_APPEND: begin
                     if (count_ff < CW'(DEPTH)) begin
                        wr_en         = 1'b1;
                        count_in      = count_ff + CW'(1);
                        res_status_in = STATUS_APPENDED;
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_QUERY_DONE;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (probe_live) begin
               rd_en  = 1'b1;
               mid_in = mid_calc[AW-1:0];
            end else if (!dir_ff) begin
               // leftmost search done, rightmost only runs after a hit
               if (hit_vld_ff) begin
                  res_found_in = 1'b1;
                  res_first_in = INDEX_W'(hit_idx_ff);
                  dir_in       = 1'b1;
                  lo_in        = '0;
                  hi_in        = count_ff;
                  hit_vld_in   = 1'b0;
               end
            end else begin
               res_last_in = hit_vld_ff ? INDEX_W'(hit_idx_ff) : NONE_INDEX;
            end
         end
         ST_COMPARE: begin
            lo_in = step_lo;
            hi_in = step_hi;
            if (step_hit) begin
               hit_vld_in = 1'b1;
               hit_idx_in = mid_ff;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_first_in  = res_first_ff;
               rsp_last_in   = res_last_ff;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      dir_ff        <= dir_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      hit_vld_ff    <= hit_vld_in;
      hit_idx_ff    <= hit_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_first_ff  <= res_first_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // element store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[mid_calc[AW-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_last_index  = rsp_last_ff;

   `SRS_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SRS_ASSERT_HOLDS(a_compare_window, clock, reset, state_ff == ST_COMPARE, lo_ff < hi_ff)
   `SRS_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_accept, state_ff != ST_IDLE)
   `SRS_ASSERT_HOLDS(a_miss_indices, clock, reset, rsp_valid_ff && !rsp_found_ff,
      rsp_first_ff == NONE_INDEX && rsp_last_ff == NONE_INDEX)

endmodule
